@@ design/tpcm_pkg.sv @@
// Package for the thermistor polynomial channel monitor.
// Holds the field widths, register indexes, state types and the interface structs.
// No dependencies; the design files that use it refer to it by scoped names.
`default_nettype none

package tpcm_pkg;

   localparam int CHANNELS_DEF    = 7;
   localparam int MIN_CEILING_DEF = 15360;

   localparam int NUM_COEF = 7;
   localparam int COEF_W   = 32;
   localparam int VOLT_W   = 16;
   localparam int CH_W     = 7;
   localparam int TEMP_W   = 24;
   localparam int MAX_W    = 23;
   localparam int SUM_W    = 30;
   localparam int ACC_W    = 42;
   localparam int LO_W     = 21;
   localparam int MUL_A_W  = 22;
   localparam int MUL_B_W  = 17;
   localparam int MUL_P_W  = 39;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 128;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAST   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_LIMITS = 3'd7;
   localparam logic [COEF_W-1:0]    VOLT_LIMITS_RST = 32'hFFFF_0000;

   typedef enum logic [1:0] {
      T_IDLE,
      T_CONV,
      T_STAT,
      T_HOLD
   } top_state_type;

   typedef enum logic [2:0] {
      P_IDLE,
      P_MUL_LO,
      P_MUL_HI,
      P_ACC,
      P_FIN
   } poly_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_DIV_LOAD,
      S_DIV,
      S_DONE
   } stat_state_type;

   typedef struct packed {
      logic                     done;
      logic signed [TEMP_W-1:0] temperature;
   } poly_res_type;

   typedef struct packed {
      logic start;
      logic ch_ok;
   } stat_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TEMP_W-1:0] min_temp;
      logic        [MAX_W-1:0]  max_temp;
      logic signed [SUM_W-1:0]  sum_temp;
      logic signed [TEMP_W-1:0] avg_temp;
   } stat_res_type;

endpackage

`default_nettype wire

@@ design/thermistor_poly_channel_monitor_unit.sv @@
// Thermistor channel monitor: clamps a sensor voltage, converts it to a temperature with a
// degree-6 polynomial, stores it per channel and reports table statistics.
// Depends on tpcm_pkg, tpcm_poly and tpcm_stats.
//
// Usage: an item on the req channel carries a channel index and a Q4.12 voltage. Each item
// produces exactly one item on the rsp channel with the status flag in rsp_tuser and the
// temperature, minimum, maximum, sum and average packed in rsp_tdata.
// The polynomial coefficients and the voltage limits are written through the csr port,
// one register per cycle, while no item is in flight.
// req_tready returns in the same cycle that rsp_tvalid rises, so no item is taken before the
// last one has finished. The time is set by the Horner loop on the single shared multiplier
// (low half product, high half product and accumulate for each term, then a finish step), the
// one-entry-per-cycle walk over the table, and a load step and a multiply step that divide
// the sum by the channel count through a constant reciprocal.
// One item is processed at a time; req_tready is high only while the block is waiting for
// an item, and it is also high while a finished result still waits in the output register.
// If the receiver stalls and a second result completes, the block holds it internally and
// stops taking items until the output register drains.
// Reset clears the coefficients, sets the voltage limits to their full span, marks every
// table entry as zero and drops any pending result.
`default_nettype none

module thermistor_poly_channel_monitor_unit #(
   parameter int CHANNELS    = tpcm_pkg::CHANNELS_DEF,
   parameter int MIN_CEILING = tpcm_pkg::MIN_CEILING_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // channel [6:0], voltage [22:7], zero [23]
   input  wire logic [tpcm_pkg::REQ_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // temperature [23:0], min_temp [47:24], max_temp [70:48], sum_temp [100:71],
   // avg_temp [124:101], zero [127:125]
   output logic [tpcm_pkg::RSP_W-1:0]             rsp_tdata,
   // status [0]
   output logic                                   rsp_tuser,
   input  wire logic                              csr_wr_en,
   input  wire logic [tpcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tpcm_pkg::COEF_W-1:0]       csr_wdata
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   tpcm_pkg::top_state_type state_ff, state_in;

   logic [tpcm_pkg::NUM_COEF-1:0][tpcm_pkg::COEF_W-1:0] coef_ff;
   logic [tpcm_pkg::COEF_W-1:0] limits_ff;
   logic                        ch_ok_ff;
   logic [AW-1:0]               addr_ff;
   logic signed [tpcm_pkg::TEMP_W-1:0] temp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tpcm_pkg::RSP_W-1:0]  rsp_data_ff;
   logic                        rsp_user_ff;

   logic [tpcm_pkg::CH_W-1:0]   req_ch;
   logic [tpcm_pkg::VOLT_W-1:0] req_volt;
   logic                        req_ch_ok;
   logic                        poly_start, out_free, out_load, ready;

   tpcm_pkg::poly_res_type poly_res;
   tpcm_pkg::stat_req_type stat_req;
   tpcm_pkg::stat_res_type stat_res;

   assign req_ch    = req_tdata[6:0];
   assign req_volt  = req_tdata[22:7];
   assign req_ch_ok = ({1'b0, req_ch} < 8'(CHANNELS));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   tpcm_poly u_poly (
      .clock      (clock),
      .reset      (reset),
      .start      (poly_start),
      .voltage    (req_volt),
      .coef       (coef_ff),
      .volt_limits(limits_ff),
      .res        (poly_res)
   );

   tpcm_stats #(
      .CHANNELS   (CHANNELS),
      .MIN_CEILING(MIN_CEILING)
   ) u_stats (
      .clock      (clock),
      .reset      (reset),
      .req        (stat_req),
      .wr_addr    (addr_ff),
      .temperature(poly_res.temperature),
      .res        (stat_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpcm_pkg::T_IDLE: begin
            if (req_tvalid) begin
               state_in = tpcm_pkg::T_CONV;
            end
         end
         tpcm_pkg::T_CONV: begin
            if (poly_res.done) begin
               state_in = tpcm_pkg::T_STAT;
            end
         end
         tpcm_pkg::T_STAT: begin
            if (stat_res.done) begin
               state_in = out_free ? tpcm_pkg::T_IDLE : tpcm_pkg::T_HOLD;
            end
         end
         tpcm_pkg::T_HOLD: begin
            if (out_free) begin
               state_in = tpcm_pkg::T_IDLE;
            end
         end
         default: state_in = tpcm_pkg::T_IDLE;
      endcase
   end

   always_comb begin
      ready          = 1'b0;
      poly_start     = 1'b0;
      stat_req.start = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         tpcm_pkg::T_IDLE: begin
            ready      = 1'b1;
            poly_start = req_tvalid;
         end
         tpcm_pkg::T_CONV: stat_req.start = poly_res.done;
         tpcm_pkg::T_STAT: out_load = stat_res.done & out_free;
         tpcm_pkg::T_HOLD: out_load = out_free;
         default: begin
            ready = 1'b0;
         end
      endcase
      stat_req.ch_ok = ch_ok_ff;
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpcm_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
         coef_ff      <= '0;
         limits_ff    <= tpcm_pkg::VOLT_LIMITS_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (csr_index == tpcm_pkg::CSR_VOLT_LIMITS) begin
               limits_ff <= csr_wdata;
            end else if (csr_index <= tpcm_pkg::CSR_COEF_LAST) begin
               coef_ff[csr_index] <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (poly_start) begin
         ch_ok_ff <= req_ch_ok;
         addr_ff  <= req_ch[AW-1:0];
      end
      if (stat_req.start) begin
         temp_ff <= poly_res.temperature;
      end
      if (out_load) begin
         rsp_user_ff <= !ch_ok_ff;
         rsp_data_ff <= {3'b000, stat_res.avg_temp, stat_res.sum_temp, stat_res.max_temp,
                         stat_res.min_temp, temp_ff};
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_poly_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      poly_res.done |-> state_ff == tpcm_pkg::T_CONV)
      else $error("Conversion finished outside the conversion phase.");

   a_stat_done_in_stat: assert property (@(posedge clock) disable iff (reset)
      stat_res.done |-> state_ff == tpcm_pkg::T_STAT)
      else $error("Statistics finished outside the statistics phase.");

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("A second item was taken while one is in flight.");

   a_min_below_ceiling: assert property (@(posedge clock) disable iff (reset)
      stat_res.done |-> stat_res.min_temp <= MIN_CEILING)
      else $error("Reported minimum exceeds the ceiling.");

endmodule

`default_nettype wire

@@ design/tpcm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the per-channel temperature table.
`default_nettype none

module tpcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 7,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/tpcm_poly.sv @@
// Voltage clamp and degree-6 Horner evaluation on one shared 22x17 multiplier.
// Each Horner step runs through a low half product, a high half product and an accumulate step.
// Depends on tpcm_pkg.
`default_nettype none

module tpcm_poly (
   input  wire logic                                                clock,
   input  wire logic                                                reset,
   input  wire logic                                                start,
   input  wire logic [tpcm_pkg::VOLT_W-1:0]                         voltage,
   input  wire logic [tpcm_pkg::NUM_COEF-1:0][tpcm_pkg::COEF_W-1:0] coef,
   input  wire logic [tpcm_pkg::COEF_W-1:0]                         volt_limits,
   output tpcm_pkg::poly_res_type                                   res
);

   localparam logic signed [47:0] ACC_POS = 48'sh0100_0000_0000;
   localparam logic signed [47:0] ACC_NEG = -ACC_POS;
   localparam logic signed [33:0] T_POS   = 34'sd8388607;
   localparam logic signed [33:0] T_NEG   = -34'sd8388608;

   tpcm_pkg::poly_state_type state_ff, state_in;

   logic        [tpcm_pkg::VOLT_W-1:0]  v_ff, v_in;
   logic signed [tpcm_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic        [2:0]                   k_ff, k_in;
   logic signed [tpcm_pkg::MUL_P_W-1:0] prod_lo_ff, prod_hi_ff;

   logic load_init, load_lo, load_hi, load_acc, sel_hi, done;

   logic [tpcm_pkg::VOLT_W-1:0] lim_lo, lim_hi, v_low, v_clamp;
   logic signed [tpcm_pkg::MUL_A_W-1:0] mul_a;
   logic signed [tpcm_pkg::MUL_B_W-1:0] mul_b;
   logic signed [tpcm_pkg::MUL_P_W-1:0] mul_p;
   logic signed [59:0] prod_full;
   logic signed [47:0] step_sum, step_sat;
   logic [tpcm_pkg::COEF_W-1:0] coef_sel, coef_top;
   logic signed [33:0] t_sh;

   // Clamp: the upper limit wins when the limits cross.
   always_comb begin
      lim_lo  = volt_limits[15:0];
      lim_hi  = volt_limits[31:16];
      v_low   = (voltage < lim_lo) ? lim_lo : voltage;
      v_clamp = (v_low > lim_hi) ? lim_hi : v_low;
   end

   // The accumulator is split into a signed high half and an unsigned low half.
   assign mul_a = sel_hi ? {acc_ff[tpcm_pkg::ACC_W-1], acc_ff[tpcm_pkg::ACC_W-1:tpcm_pkg::LO_W]}
                         : {1'b0, acc_ff[tpcm_pkg::LO_W-1:0]};
   assign mul_b = {1'b0, v_ff};
   assign mul_p = mul_a * mul_b;

   always_comb begin
      coef_sel  = coef[k_ff];
      coef_top  = coef[tpcm_pkg::NUM_COEF-1];
      prod_full = ({{21{prod_hi_ff[tpcm_pkg::MUL_P_W-1]}}, prod_hi_ff} <<< tpcm_pkg::LO_W)
                + {21'b0, prod_lo_ff};
      step_sum  = prod_full[59:12] + {{16{coef_sel[31]}}, coef_sel};
      if (step_sum > ACC_POS) begin
         step_sat = ACC_POS;
      end else if (step_sum < ACC_NEG) begin
         step_sat = ACC_NEG;
      end else begin
         step_sat = step_sum;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpcm_pkg::P_IDLE: begin
            if (start) begin
               state_in = tpcm_pkg::P_MUL_LO;
            end
         end
         tpcm_pkg::P_MUL_LO: state_in = tpcm_pkg::P_MUL_HI;
         tpcm_pkg::P_MUL_HI: state_in = tpcm_pkg::P_ACC;
         tpcm_pkg::P_ACC: begin
            state_in = (k_ff == 3'd0) ? tpcm_pkg::P_FIN : tpcm_pkg::P_MUL_LO;
         end
         tpcm_pkg::P_FIN: state_in = tpcm_pkg::P_IDLE;
         default: state_in = tpcm_pkg::P_IDLE;
      endcase
   end

   always_comb begin
      load_init = 1'b0;
      load_lo   = 1'b0;
      load_hi   = 1'b0;
      load_acc  = 1'b0;
      sel_hi    = 1'b0;
      done      = 1'b0;
      case (state_ff)
         tpcm_pkg::P_IDLE:   load_init = start;
         tpcm_pkg::P_MUL_LO: load_lo = 1'b1;
         tpcm_pkg::P_MUL_HI: begin
            load_hi = 1'b1;
            sel_hi  = 1'b1;
         end
         tpcm_pkg::P_ACC:    load_acc = 1'b1;
         tpcm_pkg::P_FIN:    done = 1'b1;
         default: begin
            load_init = 1'b0;
         end
      endcase
   end

   always_comb begin
      v_in   = load_init ? v_clamp : v_ff;
      acc_in = acc_ff;
      k_in   = k_ff;
      if (load_init) begin
         acc_in = {{(tpcm_pkg::ACC_W - tpcm_pkg::COEF_W){coef_top[31]}}, coef_top};
         k_in   = 3'(tpcm_pkg::NUM_COEF - 2);
      end else if (load_acc) begin
         acc_in = step_sat[tpcm_pkg::ACC_W-1:0];
         k_in   = k_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpcm_pkg::P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      acc_ff <= acc_in;
      k_ff   <= k_in;
      if (load_lo) begin
         prod_lo_ff <= mul_p;
      end
      if (load_hi) begin
         prod_hi_ff <= mul_p;
      end
   end

   always_comb begin
      t_sh     = acc_ff[tpcm_pkg::ACC_W-1:8];
      res.done = done;
      if (t_sh > T_POS) begin
         res.temperature = T_POS[tpcm_pkg::TEMP_W-1:0];
      end else if (t_sh < T_NEG) begin
         res.temperature = T_NEG[tpcm_pkg::TEMP_W-1:0];
      end else begin
         res.temperature = t_sh[tpcm_pkg::TEMP_W-1:0];
      end
   end

endmodule

`default_nettype wire

@@ design/tpcm_stats.sv @@
// Per-channel temperature table with a sequential walk for minimum, maximum and sum,
// followed by a division of the sum by the channel count through a constant reciprocal.
// Depends on tpcm_pkg and tpcm_ram.
`default_nettype none

module tpcm_stats #(
   parameter int CHANNELS    = tpcm_pkg::CHANNELS_DEF,
   parameter int MIN_CEILING = tpcm_pkg::MIN_CEILING_DEF,
   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tpcm_pkg::stat_req_type              req,
   input  wire logic [AW-1:0]                       wr_addr,
   input  wire logic signed [tpcm_pkg::TEMP_W-1:0]  temperature,
   output tpcm_pkg::stat_res_type                   res
);

   // The shift covers the full sum width plus the rounded-up base-2 logarithm of the channel
   // count, which makes the rounded-up reciprocal exact for every sum magnitude.
   localparam int     DIV_SH   = tpcm_pkg::SUM_W + AW;
   localparam int     RCP_W    = 32;
   localparam int     PROD_W   = tpcm_pkg::SUM_W + RCP_W;
   localparam longint RCP_FULL = ((64'sd1 <<< DIV_SH) + longint'(CHANNELS) - 64'sd1)
                               / longint'(CHANNELS);
   localparam logic [RCP_W-1:0] RECIP    = RCP_W'(RCP_FULL);
   localparam logic [AW-1:0]    IDX_LAST = AW'(CHANNELS - 1);

   tpcm_pkg::stat_state_type state_ff, state_in;

   logic [AW-1:0]       idx_ff, idx_in;
   logic                rd_pend_ff;
   logic                ent_vld_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic signed [tpcm_pkg::TEMP_W-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [tpcm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [tpcm_pkg::SUM_W-1:0]  q_ff, q_in;
   logic                        neg_ff, neg_in;
   logic [tpcm_pkg::TEMP_W-1:0] avg_mag_ff, avg_mag_in;

   logic init, wr_en, rd_issue, div_load, div_step, done;
   logic [tpcm_pkg::TEMP_W-1:0] rd_data;
   logic signed [tpcm_pkg::TEMP_W-1:0] entry;
   logic [PROD_W-1:0]           div_prod;
   logic [tpcm_pkg::TEMP_W-1:0] quot;

   tpcm_ram #(
      .WIDTH(tpcm_pkg::TEMP_W),
      .DEPTH(CHANNELS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(temperature),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpcm_pkg::S_IDLE: begin
            if (req.start) begin
               state_in = tpcm_pkg::S_READ;
            end
         end
         tpcm_pkg::S_READ: begin
            if (idx_ff == IDX_LAST) begin
               state_in = tpcm_pkg::S_DRAIN;
            end
         end
         tpcm_pkg::S_DRAIN:    state_in = tpcm_pkg::S_DIV_LOAD;
         tpcm_pkg::S_DIV_LOAD: state_in = tpcm_pkg::S_DIV;
         tpcm_pkg::S_DIV:      state_in = tpcm_pkg::S_DONE;
         tpcm_pkg::S_DONE:     state_in = tpcm_pkg::S_IDLE;
         default: state_in = tpcm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      init     = 1'b0;
      rd_issue = 1'b0;
      div_load = 1'b0;
      div_step = 1'b0;
      done     = 1'b0;
      case (state_ff)
         tpcm_pkg::S_IDLE:     init = req.start;
         tpcm_pkg::S_READ:     rd_issue = 1'b1;
         tpcm_pkg::S_DIV_LOAD: div_load = 1'b1;
         tpcm_pkg::S_DIV:      div_step = 1'b1;
         tpcm_pkg::S_DONE:     done = 1'b1;
         default: begin
            init = 1'b0;
         end
      endcase
      wr_en = init & req.ch_ok;
   end

   // An entry that was never written reads as zero.
   assign entry = ent_vld_ff ? rd_data : '0;

   assign div_prod = {{RCP_W{1'b0}}, q_ff} * {{tpcm_pkg::SUM_W{1'b0}}, RECIP};

   always_comb begin
      idx_in     = idx_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      q_in       = q_ff;
      neg_in     = neg_ff;
      avg_mag_in = avg_mag_ff;
      if (init) begin
         idx_in = '0;
         min_in = tpcm_pkg::TEMP_W'(MIN_CEILING);
         max_in = '0;
         sum_in = '0;
      end else begin
         if (rd_issue) begin
            idx_in = idx_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            min_in = (entry < min_ff) ? entry : min_ff;
            max_in = (entry > max_ff) ? entry : max_ff;
            sum_in = sum_ff + {{(tpcm_pkg::SUM_W - tpcm_pkg::TEMP_W){entry[23]}}, entry};
         end
      end
      if (div_load) begin
         neg_in = sum_ff[tpcm_pkg::SUM_W-1];
         q_in   = sum_ff[tpcm_pkg::SUM_W-1] ? -sum_ff : sum_ff;
      end else if (div_step) begin
         avg_mag_in = div_prod[DIV_SH +: tpcm_pkg::TEMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tpcm_pkg::S_IDLE;
         rd_pend_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_issue;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      ent_vld_ff <= valid_ff[idx_ff];
      min_ff     <= min_in;
      max_ff     <= max_in;
      sum_ff     <= sum_in;
      q_ff       <= q_in;
      neg_ff     <= neg_in;
      avg_mag_ff <= avg_mag_in;
   end

   always_comb begin
      quot         = neg_ff ? -avg_mag_ff : avg_mag_ff;
      res.done     = done;
      res.min_temp = min_ff;
      res.max_temp = max_ff[tpcm_pkg::MAX_W-1:0];
      res.sum_temp = sum_ff;
      res.avg_temp = quot;
   end

endmodule

`default_nettype wire
